@@ rtl/sli_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted list package
// Shared widths, operation and status codes and cell control type for the
// sorted list insert, delete and search block.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int OP_W  = 2;
    localparam int KEY_W = 32;
    localparam int ST_W  = 3;
    localparam int POS_W = 5;

    // Operation codes. Any code with the high bit set is a search.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_DELETED  = 3'd2;
    localparam logic [ST_W-1:0] ST_DEL_MISS = 3'd3;
    localparam logic [ST_W-1:0] ST_FOUND    = 3'd4;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd5;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic cmp_en;  // compare stored entry against the key
        logic ins_en;  // shift up and insert the key
        logic del_en;  // shift down over the matching entry
    } t_cell_ctl;

endpackage

@@ rtl/sorted_list_insert_delete_search.sv @@
// ----------------------------------------------------------------------------
// Sorted list insert, delete and search
// An accepted item passes through a compare state, then an apply state; the
// result strobe, registered from the apply state, is held for one cycle.
// A new item is taken during the apply state but not during compare (busy),
// as each item's compare pass through the cell chain needs the list the previous one left.
// Reset: synchronous, active low; empties the list. The receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_search #(
    parameter int DEPTH = sli_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [sli_pkg::OP_W-1:0]     i_opcode,
    input  logic [sli_pkg::KEY_W-1:0]    i_key_value,
    output logic                         o_valid,
    output logic [sli_pkg::ST_W-1:0]     o_status,
    output logic [sli_pkg::POS_W-1:0]    o_position,
    output logic [sli_pkg::POS_W-1:0]    o_entry_count
);

    // Count needs to hold DEPTH itself; a cell index needs only the range 0
    // to DEPTH-1.
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [sli_pkg::OP_W-1:0]    r_op;
    logic [sli_pkg::KEY_W-1:0]   r_key;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic                        r_valid;
    logic [sli_pkg::ST_W-1:0]    r_status;
    logic [sli_pkg::POS_W-1:0]   r_pos;
    logic [sli_pkg::POS_W-1:0]   r_cnt_out;

    logic                        accept;
    sli_pkg::t_cell_ctl          cell_ctl;

    logic [DEPTH-1:0][sli_pkg::KEY_W-1:0] entry;
    logic [DEPTH-1:0]            lt;
    logic [DEPTH-1:0]            first_ge;
    logic [DEPTH-1:0]            hit_vec;

    logic                        is_insert;
    logic                        is_delete;
    logic                        full;
    logic                        hit;
    logic [IW-1:0]               pos_enc;
    logic [CW-1:0]               pos;
    logic [sli_pkg::ST_W-1:0]    n_status;
    logic [CW-1:0]               n_pos;
    logic [CW+sli_pkg::POS_W-1:0] pos_ext;
    logic [CW+sli_pkg::POS_W-1:0] cnt_ext;

    // A new item may enter while the previous one is being applied: its
    // compare cycle then sees the list that the apply cycle leaves.
    assign busy   = (r_state == S_CMP);
    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = accept ? S_CMP : S_IDLE;
            S_CMP:   n_state = S_APPLY;
            S_APPLY: n_state = accept ? S_CMP : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_opcode;
            r_key <= i_key_value;
        end
    end

    // Opcode decode: only the high bit selects a search, so the unused
    // code behaves as a search.
    assign is_insert = (r_op == sli_pkg::OP_INSERT);
    assign is_delete = (r_op == sli_pkg::OP_DELETE);
    assign full      = (r_count == CW'(DEPTH));

    // The less-than flags form a thermometer code over the sorted list, so
    // at most one cell sees the boundary. Its index is the lower bound.
    always_comb begin
        pos_enc = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first_ge[i]) begin
                pos_enc = pos_enc | IW'(i);
            end
        end
    end

    assign hit = |hit_vec;
    // With every stored entry below the key and the list full, no cell sees
    // the boundary and the lower bound is the count itself.
    assign pos = (|first_ge) ? CW'(pos_enc) : r_count;

    assign cell_ctl.cmp_en = (r_state == S_CMP);
    assign cell_ctl.ins_en = (r_state == S_APPLY) && is_insert && !full;
    assign cell_ctl.del_en = (r_state == S_APPLY) && is_delete && hit;

    always_comb begin
        n_count  = r_count;
        n_pos    = r_count;
        n_status = sli_pkg::ST_NOTFOUND;
        if (is_insert) begin
            if (full) begin
                n_status = sli_pkg::ST_FULL;
            end else begin
                n_status = sli_pkg::ST_INSERTED;
                n_pos    = pos;
                n_count  = r_count + CW'(1);
            end
        end else if (is_delete) begin
            if (hit) begin
                n_status = sli_pkg::ST_DELETED;
                n_pos    = pos;
                n_count  = r_count - CW'(1);
            end else begin
                n_status = sli_pkg::ST_DEL_MISS;
            end
        end else begin
            if (hit) begin
                n_status = sli_pkg::ST_FOUND;
                n_pos    = pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_APPLY);
            if (r_state == S_APPLY) begin
                r_count <= n_count;
            end
        end
    end

    // Position and count are reported modulo 32.
    assign pos_ext = {{sli_pkg::POS_W{1'b0}}, n_pos};
    assign cnt_ext = {{sli_pkg::POS_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (r_state == S_APPLY) begin
            r_status  <= n_status;
            r_pos     <= pos_ext[sli_pkg::POS_W-1:0];
            r_cnt_out <= cnt_ext[sli_pkg::POS_W-1:0];
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_position    = r_pos;
    assign o_entry_count = r_cnt_out;

    // The chain: each cell sees its left neighbour's flag and entry and its
    // right neighbour's entry. The first cell sees a virtual "below" flag.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int LEFT  = (g == 0) ? 0 : g - 1;
        localparam int RIGHT = (g == DEPTH - 1) ? g : g + 1;

        logic cell_valid;
        assign cell_valid = (r_count > CW'(g));

        sli_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (cell_ctl),
            .i_valid       (cell_valid),
            .i_key         (r_key),
            .i_left_entry  (entry[LEFT]),
            .i_left_lt     ((g == 0) ? 1'b1 : lt[LEFT]),
            .i_right_entry (entry[RIGHT]),
            .o_entry       (entry[g]),
            .o_lt          (lt[g]),
            .o_first_ge    (first_ge[g]),
            .o_hit         (hit_vec[g])
        );
    end

    // The stored count never passes the depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    // A result strobe follows only an apply cycle.
    a_strobe_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_APPLY))
        else $error("result strobe without apply cycle");

    // An accepted item always goes to its compare cycle next.
    a_accept_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_CMP))
        else $error("accepted item did not enter compare");

    // The list stays sorted, so at most one cell marks the lower bound.
    a_single_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> $onehot0(first_ge))
        else $error("less-than flags are not a thermometer code");

endmodule

@@ rtl/sli_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one entry, compares it with the key and shifts to or from its
// neighbours on insert and delete.
// ----------------------------------------------------------------------------
module sli_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sli_pkg::t_cell_ctl             i_ctl,
    input  logic                           i_valid,
    input  logic [sli_pkg::KEY_W-1:0]      i_key,
    input  logic [sli_pkg::KEY_W-1:0]      i_left_entry,
    input  logic                           i_left_lt,
    input  logic [sli_pkg::KEY_W-1:0]      i_right_entry,
    output logic [sli_pkg::KEY_W-1:0]      o_entry,
    output logic                           o_lt,
    output logic                           o_first_ge,
    output logic                           o_hit
);

    logic [sli_pkg::KEY_W-1:0] r_entry;
    logic                      r_lt;
    logic                      r_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctl.cmp_en) begin
            r_lt <= i_valid && ($signed(r_entry) < $signed(i_key));
            r_eq <= i_valid && (r_entry == i_key);
        end
    end

    // Cells at or above the insert point move up; the one at the point
    // takes the key. On delete, cells from the match upwards pull down.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_en) begin
            if (!r_lt) begin
                r_entry <= i_left_lt ? i_key : i_left_entry;
            end
        end else if (i_ctl.del_en) begin
            if (!r_lt) begin
                r_entry <= i_right_entry;
            end
        end
    end

    assign o_entry    = r_entry;
    assign o_lt       = r_lt;
    assign o_first_ge = !r_lt && i_left_lt;
    assign o_hit      = r_eq && i_left_lt;

endmodule
